// ===== src/rmfw_pkg.sv =====
// shared types and constants for the recursive mutex with fifo waiters
`timescale 1ns / 1ps
`default_nettype none
package rmfw_pkg;

  localparam int TID_W    = 4;
  localparam int NUM_IDS  = 1 << TID_W;
  localparam int NEST_W   = 8;
  localparam int NEST_TOP = (1 << NEST_W) - 1;

  typedef enum logic [0:0] {
    CMD_ACQUIRE = 1'b0,
    CMD_RELEASE = 1'b1
  } cmd_e_t;

  typedef enum logic [2:0] {
    ST_GRANTED      = 3'd0,
    ST_NESTED_GRANT = 3'd1,
    ST_QUEUED       = 3'd2,
    ST_NESTED_REL   = 3'd3,
    ST_FREED        = 3'd4,
    ST_NOT_HOLDER   = 3'd5,
    ST_ALREADY_WAIT = 3'd6,
    ST_NEST_OVF     = 3'd7
  } status_e_t;

  typedef struct packed {
    cmd_e_t             cmd;
    logic [TID_W-1:0]   thread_id;
  } in_word_t;

  typedef struct packed {
    status_e_t          status;
    logic               woken_valid;
    logic [TID_W-1:0]   woken_thread;
    logic               holder_valid;
    logic [TID_W-1:0]   holder_thread;
    logic [NEST_W-1:0]  nest_count;
  } out_word_t;

  typedef struct packed {
    logic               push;
    logic               pop;
    logic [TID_W-1:0]   push_id;
  } q_ctrl_t;

  typedef struct packed {
    logic               full;
    logic               empty;
    logic [TID_W-1:0]   head_id;
  } q_stat_t;

endpackage
`default_nettype wire

// ===== src/rmfw_ram.sv =====
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module rmfw_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

// ===== src/rmfw_queue.sv =====
// fifo of waiting thread ids with head prefetch from ram
`timescale 1ns / 1ps
`default_nettype none
module rmfw_queue import rmfw_pkg::*; #(
  parameter int THREADS = 16
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire q_ctrl_t ctrl,
  output q_stat_t      stat
);

  localparam int PTR_W  = $clog2(THREADS);
  localparam int FILL_W = $clog2(THREADS + 1);
  localparam logic [PTR_W-1:0]  LAST = PTR_W'(THREADS - 1);
  localparam logic [FILL_W-1:0] CAP  = FILL_W'(THREADS);

  logic [PTR_W-1:0]  head_r, head_nxt;
  logic [PTR_W-1:0]  tail_r, tail_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic              byp_r;
  logic [TID_W-1:0]  byp_data_r;
  logic [TID_W-1:0]  rd_data;

  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
    next_slot = (p == LAST) ? '0 : p + PTR_W'(1);
  endfunction

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    fill_nxt = fill_r;
    if (ctrl.push) begin
      tail_nxt = next_slot(tail_r);
      fill_nxt = fill_r + FILL_W'(1);
    end
    if (ctrl.pop) begin
      head_nxt = next_slot(head_r);
      fill_nxt = fill_r - FILL_W'(1);
    end
  end

  rmfw_ram #(
    .WIDTH (TID_W),
    .DEPTH (THREADS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ctrl.push),
    .wr_addr (tail_r),
    .wr_data (ctrl.push_id),
    .rd_addr (head_nxt),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      fill_r <= '0;
      byp_r  <= 1'b0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      fill_r <= fill_nxt;
      byp_r  <= ctrl.push && (tail_r == head_nxt);
    end
  end

  // capture push data for a write into the slot being prefetched
  always_ff @(posedge clk) begin
    byp_data_r <= ctrl.push_id;
  end

  assign stat.full    = (fill_r >= CAP);
  assign stat.empty   = (fill_r == '0);
  assign stat.head_id = byp_r ? byp_data_r : rd_data;

`ifndef NO_ASSERTIONS
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.pop |-> !stat.empty) else $error("pop from empty wait queue");
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.push |-> !stat.full) else $error("push into full wait queue");
  a_fill_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (stat.empty |-> head_r == tail_r)) else $error("empty queue with split pointers");
`endif

endmodule
`default_nettype wire

// ===== src/rmfw_ctrl.sv =====
// lock owner, nesting depth, waiting mask and request decision
`timescale 1ns / 1ps
`default_nettype none
module rmfw_ctrl import rmfw_pkg::*; #(
  parameter int MAX_NEST = 255
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     fire,
  input  wire in_word_t word,
  input  wire q_stat_t  qstat,
  output q_ctrl_t       qctrl,
  output out_word_t     res
);

  localparam logic [NEST_W-1:0] NEST_CAP =
    NEST_W'((MAX_NEST < NEST_TOP) ? MAX_NEST : NEST_TOP);

  logic               owner_valid_r, owner_valid_nxt;
  logic [TID_W-1:0]   owner_id_r, owner_id_nxt;
  logic [NEST_W-1:0]  depth_r, depth_nxt;
  logic [NUM_IDS-1:0] mask_r, mask_nxt;
  logic               is_holder;
  logic               push_c;
  logic               pop_c;
  logic               woke;
  logic [TID_W-1:0]   woke_id;
  status_e_t          status;

  assign is_holder = owner_valid_r && (owner_id_r == word.thread_id);

  always_comb begin
    owner_valid_nxt = owner_valid_r;
    owner_id_nxt    = owner_id_r;
    depth_nxt       = depth_r;
    mask_nxt        = mask_r;
    push_c          = 1'b0;
    pop_c           = 1'b0;
    woke            = 1'b0;
    woke_id         = '0;
    status          = ST_NOT_HOLDER;
    case (word.cmd)
      CMD_ACQUIRE: begin
        if (is_holder) begin
          if (depth_r >= NEST_CAP) begin
            status = ST_NEST_OVF;
          end else begin
            depth_nxt = depth_r + NEST_W'(1);
            status    = ST_NESTED_GRANT;
          end
        end else if (!owner_valid_r) begin
          owner_valid_nxt = 1'b1;
          owner_id_nxt    = word.thread_id;
          depth_nxt       = NEST_W'(1);
          status          = ST_GRANTED;
        end else if (mask_r[word.thread_id] || qstat.full) begin
          status = ST_ALREADY_WAIT;
        end else begin
          push_c                   = 1'b1;
          mask_nxt[word.thread_id] = 1'b1;
          status                   = ST_QUEUED;
        end
      end
      CMD_RELEASE: begin
        if (!is_holder) begin
          status = ST_NOT_HOLDER;
        end else if (depth_r > NEST_W'(1)) begin
          depth_nxt = depth_r - NEST_W'(1);
          status    = ST_NESTED_REL;
        end else begin
          owner_valid_nxt = 1'b0;
          owner_id_nxt    = '0;
          depth_nxt       = '0;
          if (!qstat.empty) begin
            pop_c                  = 1'b1;
            woke                   = 1'b1;
            woke_id                = qstat.head_id;
            mask_nxt[qstat.head_id] = 1'b0;
          end
          status = ST_FREED;
        end
      end
      default: begin
        status = ST_NOT_HOLDER;
      end
    endcase
  end

  assign qctrl.push    = fire && push_c;
  assign qctrl.pop     = fire && pop_c;
  assign qctrl.push_id = word.thread_id;

  assign res.status        = status;
  assign res.woken_valid   = woke;
  assign res.woken_thread  = woke_id;
  assign res.holder_valid  = owner_valid_nxt;
  assign res.holder_thread = owner_valid_nxt ? owner_id_nxt : '0;
  assign res.nest_count    = owner_valid_nxt ? depth_nxt : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owner_valid_r <= 1'b0;
      owner_id_r    <= '0;
      depth_r       <= '0;
      mask_r        <= '0;
    end else if (fire) begin
      owner_valid_r <= owner_valid_nxt;
      owner_id_r    <= owner_id_nxt;
      depth_r       <= depth_nxt;
      mask_r        <= mask_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_held_depth: assert property (@(posedge clk) disable iff (!rst_n)
    owner_valid_r |-> (depth_r != '0) && (depth_r <= NEST_CAP))
    else $error("held lock with bad nesting depth");
  a_free_depth: assert property (@(posedge clk) disable iff (!rst_n)
    !owner_valid_r |-> (depth_r == '0) && (owner_id_r == '0))
    else $error("free lock keeps owner state");
  a_empty_mask: assert property (@(posedge clk) disable iff (!rst_n)
    qstat.empty |-> (mask_r == '0)) else $error("waiting mask set with empty queue");
`endif

endmodule
`default_nettype wire

// ===== src/recursive_mutex_fifo_waiters.sv =====
// top level: recursive mutex over a binary semaphore with a fifo of waiters
// result: registered, valid in the cycle after its request word is accepted
// throughput: one request word per cycle while out_ready holds, set by the lock update
// made when a word is accepted and the wait queue head prefetched from the ram read port
// reset: synchronous, clears owner, depth, waiting mask and queue pointers
// the wait queue ram is not cleared; only written slots are ever popped
`timescale 1ns / 1ps
`default_nettype none
module recursive_mutex_fifo_waiters import rmfw_pkg::*; #(
  parameter int THREADS  = 16,
  parameter int MAX_NEST = 255
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_word_t  in_word,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_word_t      out_word
);

  logic      fire;
  logic      out_valid_r, out_valid_nxt;
  out_word_t out_word_r;
  out_word_t res;
  q_ctrl_t   qctrl;
  q_stat_t   qstat;

  assign in_ready = !out_valid_r || out_ready;
  assign fire     = in_valid && in_ready;

  rmfw_ctrl #(
    .MAX_NEST (MAX_NEST)
  ) u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .word  (in_word),
    .qstat (qstat),
    .qctrl (qctrl),
    .res   (res)
  );

  rmfw_queue #(
    .THREADS (THREADS)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (qctrl),
    .stat  (qstat)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_word_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

`ifndef NO_ASSERTIONS
  a_woken_freed: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_word_r.woken_valid) |-> (out_word_r.status == ST_FREED))
    else $error("waiter woken without a final release");
  a_fire_loads: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid_r) else $error("accepted word left no result");
  a_free_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_word_r.holder_valid) |->
      (out_word_r.nest_count == '0) && (out_word_r.holder_thread == '0))
    else $error("free lock result carries holder data");
`endif

endmodule
`default_nettype wire

// ===== verif/recursive_mutex_fifo_waiters_tb.sv =====
// testbench for the recursive mutex with fifo waiters: predicts and checks every result word
`timescale 1ns / 1ps
module recursive_mutex_fifo_waiters_tb;
  import rmfw_pkg::*;

  localparam int STALL_LIMIT = 4000;

  class lock_tracker;
    logic               held = 1'b0;
    logic [TID_W-1:0]   holder = '0;
    logic [NEST_W-1:0]  depth = '0;
    logic [TID_W-1:0]   ring [NUM_IDS];
    logic [TID_W-1:0]   head = '0;
    logic [TID_W-1:0]   tail = '0;
    logic [TID_W:0]     fill = '0;
    logic [NUM_IDS-1:0] waiting = '0;
    out_word_t          pending_results [$];
    int                 woken_ids [$];
    int                 errors = 0;

    function void accept_request(in_word_t w);
      out_word_t        r;
      logic             is_holder;
      logic [TID_W-1:0] id;
      id = w.thread_id;
      r = '0;
      is_holder = held && holder == id;
      if (w.cmd == CMD_ACQUIRE) begin
        if (is_holder) begin
          if (depth >= NEST_TOP) begin
            r.status = ST_NEST_OVF;
          end else begin
            depth++;
            r.status = ST_NESTED_GRANT;
          end
        end else if (!held) begin
          held = 1'b1;
          holder = id;
          depth = 1;
          r.status = ST_GRANTED;
        end else if (waiting[id] || fill >= NUM_IDS) begin
          r.status = ST_ALREADY_WAIT;
        end else begin
          ring[tail] = id;
          tail++;
          fill++;
          waiting[id] = 1'b1;
          r.status = ST_QUEUED;
        end
      end else begin
        if (!is_holder) begin
          r.status = ST_NOT_HOLDER;
        end else if (depth > 1) begin
          depth--;
          r.status = ST_NESTED_REL;
        end else begin
          held = 1'b0;
          holder = '0;
          depth = '0;
          if (fill > 0) begin
            r.woken_valid = 1'b1;
            r.woken_thread = ring[head];
            waiting[ring[head]] = 1'b0;
            woken_ids.push_back(ring[head]);
            head++;
            fill--;
          end
          r.status = ST_FREED;
        end
      end
      r.holder_valid = held;
      r.holder_thread = held ? holder : '0;
      r.nest_count = held ? depth : '0;
      pending_results.push_back(r);
    endfunction

    function void check_field(string name, int want, int got);
      if (want != got) begin
        $display("%0t ns: %s expected %0d got %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(out_word_t got);
      out_word_t want;
      if (pending_results.size() == 0) begin
        $display("%0t ns: unexpected result word %h", $time, got);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      check_field("status", want.status, got.status);
      check_field("woken_valid", want.woken_valid, got.woken_valid);
      check_field("woken_thread", want.woken_thread, got.woken_thread);
      check_field("holder_valid", want.holder_valid, got.holder_valid);
      check_field("holder_thread", want.holder_thread, got.holder_thread);
      check_field("nest_count", want.nest_count, got.nest_count);
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_word;

  lock_tracker tracker = new;
  bit          in_calm = 1'b0;
  bit          out_calm = 1'b0;
  int          idle_cycles = 0;

  always #10 clk = ~clk;

  recursive_mutex_fifo_waiters dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

  function automatic int pick_gap(bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic in_word_t make_req(cmd_e_t c, int id);
    in_word_t w;
    w.cmd = c;
    w.thread_id = id[TID_W-1:0];
    return w;
  endfunction

  // flood fills the wait queue, drain empties it, mixed does both
  function automatic in_word_t next_request(int mode);
    int r;
    int id;
    int t_retry;
    int t_nest;
    int t_rel;
    int t_acq;
    r = $urandom_range(0, 99);
    id = $urandom_range(0, NUM_IDS - 1);
    case (mode)
      0: begin
        t_retry = 15; t_nest = 20; t_rel = 35; t_acq = 90;
      end
      1: begin
        t_retry = 30; t_nest = 35; t_rel = 85; t_acq = 95;
      end
      default: begin
        t_retry = 25; t_nest = 35; t_rel = 65; t_acq = 90;
      end
    endcase
    if (r < t_retry && tracker.woken_ids.size() > 0)
      return make_req(CMD_ACQUIRE, tracker.woken_ids.pop_front());
    if (r < t_nest && tracker.held && tracker.depth < 6)
      return make_req(CMD_ACQUIRE, tracker.holder);
    if (r < t_rel && tracker.held)
      return make_req(CMD_RELEASE, tracker.holder);
    if (r < t_acq)
      return make_req(CMD_ACQUIRE, id);
    return make_req(CMD_RELEASE, id);
  endfunction

  task automatic pause_sender(int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_req(in_word_t w);
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (!in_ready);
    tracker.accept_request(w);
    pause_sender(pick_gap(in_calm));
  endtask

  task automatic drain_results();
    pause_sender(1);
    while (tracker.pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic wake_all_waiters();
    int id;
    while (tracker.woken_ids.size() > 0) begin
      id = tracker.woken_ids.pop_front();
      send_req(make_req(CMD_ACQUIRE, id));
      send_req(make_req(CMD_RELEASE, id));
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) tracker.check_result(out_word);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= STALL_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int gap;
    @(posedge clk);
    forever begin
      gap = pick_gap(out_calm);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  initial begin
    int mode;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // release on a free lock, grant, nesting, queueing and repeat waits
    send_req(make_req(CMD_RELEASE, 0));
    send_req(make_req(CMD_ACQUIRE, 0));
    send_req(make_req(CMD_ACQUIRE, 0));
    send_req(make_req(CMD_ACQUIRE, 15));
    send_req(make_req(CMD_ACQUIRE, 15));
    send_req(make_req(CMD_RELEASE, 15));
    send_req(make_req(CMD_ACQUIRE, 7));
    send_req(make_req(CMD_RELEASE, 0));
    send_req(make_req(CMD_RELEASE, 0));
    // queued thread takes a free lock while its entry stays queued
    send_req(make_req(CMD_ACQUIRE, 7));
    send_req(make_req(CMD_ACQUIRE, 15));
    send_req(make_req(CMD_RELEASE, 7));
    send_req(make_req(CMD_ACQUIRE, 15));
    send_req(make_req(CMD_RELEASE, 15));
    tracker.woken_ids.delete();

    // fill the wait queue to the brim, holder included
    send_req(make_req(CMD_ACQUIRE, 1));
    send_req(make_req(CMD_ACQUIRE, 3));
    send_req(make_req(CMD_ACQUIRE, 4));
    send_req(make_req(CMD_RELEASE, 1));
    send_req(make_req(CMD_ACQUIRE, 4));
    for (int id = 0; id < NUM_IDS; id++) send_req(make_req(CMD_ACQUIRE, id));
    send_req(make_req(CMD_ACQUIRE, 5));
    send_req(make_req(CMD_RELEASE, 4));
    send_req(make_req(CMD_RELEASE, 4));
    wake_all_waiters();

    // nesting up to the cap and one past it, then back down
    repeat (NEST_TOP + 1) send_req(make_req(CMD_ACQUIRE, 9));
    repeat (NEST_TOP + 1) send_req(make_req(CMD_RELEASE, 9));
    drain_results();

    for (int blk = 0; blk < 5; blk++) begin
      in_calm = (blk == 1);
      out_calm = (blk == 2) || (blk == 1);
      for (int seg = 0; seg < 10; seg++) begin
        mode = $urandom_range(0, 2);
        repeat (25) send_req(next_request(mode));
      end
      drain_results();
    end

    wake_all_waiters();
    drain_results();
    repeat (10) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
